// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the rgb to hsl converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned LSUM_W  = 9;
  localparam int unsigned DEN_S_W = 8;
  localparam int unsigned DEN_H_W = 11;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned HUE_W   = 16;
  localparam int unsigned N_CELLS = Q_W;

  localparam logic [LSUM_W-1:0] HALF_SUM = 9'd255;
  localparam logic [LSUM_W-1:0] FULL_SUM = 9'd510;

  // hue sector offsets, in units of the spread
  localparam logic [2:0] OFF_RED_LOW = 3'd0;
  localparam logic [2:0] OFF_GREEN   = 3'd2;
  localparam logic [2:0] OFF_BLUE    = 3'd4;
  localparam logic [2:0] OFF_RED_WRAP = 3'd6;

  // one item as it travels down the divider cells
  typedef struct packed {
    logic               grey;
    logic [LSUM_W-1:0]  lsum;
    logic [DEN_S_W-1:0] den_s;
    logic [DEN_H_W-1:0] den_h;
    logic [REM_W-1:0]   rem_s;
    logic [REM_W-1:0]   rem_h;
    logic [Q_W-1:0]     q_s;
    logic [Q_W-1:0]     q_h;
  } cell_data_t;

endpackage

`default_nettype wire

// ===== rtl/rhc_if.sv =====
// ----------------------------------------------------------------------------
// rhc_pix_if / rhc_hsl_if
// Valid/ready channels for pixels in and hsl results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;

  modport source (output valid, output pixel_argb, input ready);
  modport sink   (input valid, input pixel_argb, output ready);
endinterface

interface rhc_hsl_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue_fraction;
  logic [16:0] saturation_fraction;
  logic [8:0]  lightness_sum;

  modport source (output valid, output hue_fraction, output saturation_fraction,
                  output lightness_sum, input ready);
  modport sink   (input valid, input hue_fraction, input saturation_fraction,
                  input lightness_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts ARGB pixels to fixed point hue, saturation and lightness.
// ----------------------------------------------------------------------------
// Usage:
//   pixel carries one 32-bit ARGB item per handshake; alpha is ignored.
//   hsl returns one item per pixel, in order: hue as a Q0.16 turn,
//   saturation as Q1.16 and lightness as the sum max+min.
//   The pipeline is one stage for the max/min search and the divisors,
//   then a row of 17 cells, each producing one quotient bit of both
//   divisions. The last cell is the output register.
//   Throughput is one item per cycle while hsl is not stalled. The whole row
//   advances whenever the output register is empty or being taken, so pixel.ready follows
//   hsl.ready; a stall holds every stage in place and nothing is lost.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter import rhc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  rhc_pix_if.sink    pixel,
  rhc_hsl_if.source  hsl
);

  logic       en;
  logic       v   [N_CELLS+1];
  cell_data_t dat [N_CELLS+1];

  assign en          = !v[N_CELLS] || hsl.ready;
  assign pixel.ready = en;

  rhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pixel.valid),
    .pixel_argb (pixel.pixel_argb),
    .out_valid  (v[0]),
    .out_data   (dat[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[i]),
      .in_data   (dat[i]),
      .out_valid (v[i+1]),
      .out_data  (dat[i+1])
    );
  end

  // grey pixels have no hue and no saturation
  assign hsl.valid               = v[N_CELLS];
  assign hsl.hue_fraction        = dat[N_CELLS].grey ? '0 : dat[N_CELLS].q_h[HUE_W-1:0];
  assign hsl.saturation_fraction = dat[N_CELLS].grey ? '0 : dat[N_CELLS].q_s;
  assign hsl.lightness_sum       = dat[N_CELLS].lsum;

endmodule

`default_nettype wire

// ===== rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Max/min search, lightness, divisors and hue numerator; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front import rhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] pixel_argb,
  output logic             out_valid,
  output cell_data_t       out_data
);

  logic [CHAN_W-1:0]  r, g, b, mx, mn, d;
  logic [LSUM_W-1:0]  sum;
  logic [2:0]         off;
  logic signed [REM_W-1:0] num;
  logic [DEN_H_W-1:0] offd;
  logic [REM_W-1:0]   top;
  cell_data_t         data_next;

  always_comb begin
    r = pixel_argb[23:16];
    g = pixel_argb[15:8];
    b = pixel_argb[7:0];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    // ties go red, then green, then blue
    if (mx == r) begin
      num = $signed({4'b0, g}) - $signed({4'b0, b});
      off = (g < b) ? OFF_RED_WRAP : OFF_RED_LOW;
    end else if (mx == g) begin
      num = $signed({4'b0, b}) - $signed({4'b0, r});
      off = OFF_GREEN;
    end else begin
      num = $signed({4'b0, r}) - $signed({4'b0, g});
      off = OFF_BLUE;
    end
    offd = DEN_H_W'(off) * DEN_H_W'(d);
    top  = REM_W'($signed({1'b0, offd}) + num);

    data_next.grey  = (d == '0);
    data_next.lsum  = sum;
    data_next.den_s = (sum <= HALF_SUM) ? sum[DEN_S_W-1:0]
                                        : DEN_S_W'(FULL_SUM - sum);
    data_next.den_h = DEN_H_W'(d) * DEN_H_W'(3'd6);
    data_next.rem_s = REM_W'(d);
    data_next.rem_h = top;
    data_next.q_s   = '0;
    data_next.q_h   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhc_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_cell
// One restoring division step for both saturation and hue quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_cell import rhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  cell_data_t       in_data,
  output logic             out_valid,
  output cell_data_t       out_data
);

  logic             bit_s, bit_h;
  logic [REM_W-1:0] sub_s, sub_h;
  cell_data_t       data_next;

  always_comb begin
    bit_s = in_data.rem_s >= REM_W'(in_data.den_s);
    bit_h = in_data.rem_h >= REM_W'(in_data.den_h);
    sub_s = bit_s ? in_data.rem_s - REM_W'(in_data.den_s) : in_data.rem_s;
    sub_h = bit_h ? in_data.rem_h - REM_W'(in_data.den_h) : in_data.rem_h;
    data_next       = in_data;
    data_next.rem_s = {sub_s[REM_W-2:0], 1'b0};
    data_next.rem_h = {sub_h[REM_W-2:0], 1'b0};
    data_next.q_s   = {in_data.q_s[Q_W-2:0], bit_s};
    data_next.q_h   = {in_data.q_h[Q_W-2:0], bit_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker
// Port level checks on the rgb to hsl converter.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] hue,
  input wire logic [16:0] sat,
  input wire logic [8:0]  lsum
);

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result offered straight after reset");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat[16] |-> sat[15:0] == 16'd0)
    else $error("saturation above one");

  a_lsum_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lsum != 9'd511)
    else $error("lightness sum out of range");

  // zero saturation only for grey, which also has zero hue
  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat == 17'd0 |-> hue == 16'd0)
    else $error("grey item with nonzero hue");

endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (hsl.valid),
  .out_ready (hsl.ready),
  .hue       (hsl.hue_fraction),
  .sat       (hsl.saturation_fraction),
  .lsum      (hsl.lightness_sum)
);

`default_nettype wire

// ===== tb/rgb_to_hsl_converter_test.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_test
// Drives ARGB pixels into the converter and checks each hsl item against an
// in-bench predictor, in order, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat;
    logic [8:0]  lsum;
  } hsl_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhc_pix_if pixel ();
  rhc_hsl_if hsl ();

  rgb_to_hsl_converter uut (.clk(clk), .rst(rst), .pixel(pixel), .hsl(hsl));

  always #1 clk = ~clk;

  logic [31:0] pending_pixels[$];
  hsl_t        expected_hsl[$];
  int          errors = 0;
  int          checked = 0;
  int          cycles = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_off = 0;

  function automatic hsl_t convert_pixel(logic [31:0] px);
    hsl_t        res;
    int unsigned r, g, b, mx, mn, sum, d, den, top, off;
    int          num;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    d = mx - mn;
    res.lsum = sum[8:0];
    res.hue = '0;
    res.sat = '0;
    if (d > 0) begin
      den = (sum <= 255) ? sum : 510 - sum;
      res.sat = 17'((d * 65536) / den);
      // ties go red, then green, then blue
      if (mx == r) begin
        num = int'(g) - int'(b);
        off = (g < b) ? 6 : 0;
      end else if (mx == g) begin
        num = int'(b) - int'(r);
        off = 2;
      end else begin
        num = int'(r) - int'(g);
        off = 4;
      end
      top = int'(off * d) + num;
      res.hue = 16'((top * 65536) / (6 * d));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
      pixel.pixel_argb <= '0;
    end else if (!pixel.valid || pixel.ready) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        pixel.valid <= 1'b1;
        pixel.pixel_argb <= pending_pixels.pop_front();
      end else begin
        pixel.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel.valid && pixel.ready)
      expected_hsl.push_back(convert_pixel(pixel.pixel_argb));
  end

  // monitor
  always @(posedge clk) begin
    hsl_t want;
    cycles <= cycles + 1;
    if (rst) begin
      hsl.ready <= 1'b0;
    end else begin
      if (hsl.valid && hsl.ready) begin
        if (expected_hsl.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_hsl.pop_front();
          if (hsl.hue_fraction !== want.hue)
            report_mismatch("hue", hsl.hue_fraction, want.hue);
          if (hsl.saturation_fraction !== want.sat)
            report_mismatch("saturation", hsl.saturation_fraction, want.sat);
          if (hsl.lightness_sum !== want.lsum)
            report_mismatch("lightness", hsl.lightness_sum, want.lsum);
        end
        checked++;
      end
      if (hold_off > 0) begin
        hsl.ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        hsl.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rgb_to_hsl_converter");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    logic [7:0]  base;
    px = $urandom;
    base = px[7:0];
    // ties, greys and near-ties often, to stress the max choice
    case ($urandom_range(5))
      0: px[15:0] = {base, base};
      1: px[23:8] = {base, base};
      2: px[23:0] = {base, base, base};
      3: px[15:0] = {px[23:16] ^ 8'(($urandom_range(2))), base};
      default: ;
    endcase
    return px;
  endfunction

  task automatic run_phase(int n, int s_pct, int k_pct);
    src_idle_pct = s_pct;
    snk_idle_pct = k_pct;
    repeat (n) pending_pixels.push_back(rand_pixel());
    wait (pending_pixels.size() == 0);
  endtask

  initial begin
    logic [31:0] directed[$];
    pixel.valid = 1'b0;
    pixel.pixel_argb = '0;
    hsl.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    directed = '{32'h00000000, 32'hFFFFFFFF, 32'h00FF0000, 32'h0000FF00,
                 32'h000000FF, 32'hFF00FFFF, 32'h12FFFF00, 32'hAAFF00FF,
                 32'h00FFFFFF, 32'h00808080, 32'h007F7F7F, 32'h00FF00FE,
                 32'h00FE00FF, 32'h00FF0001, 32'h00010000, 32'h00FFFEFF,
                 32'h00FF8000, 32'h0000FF80, 32'h008000FF, 32'h00010203,
                 32'h00FDFEFF, 32'h55800001, 32'hA5807F80};
    src_idle_pct = 0;
    snk_idle_pct = 0;
    foreach (directed[i]) pending_pixels.push_back(directed[i]);
    wait (pending_pixels.size() == 0);
    run_phase(250, 32, 46);
    run_phase(250, 46, 32);
    // long receiver stall while the sender keeps offering
    @(posedge clk);
    hold_off <= 80;
    run_phase(200, 0, 0);
    wait (expected_hsl.size() == 0);
    repeat (40) @(posedge clk);
    $display("converted %0d pixels: corners, ties, greys and random, with idling", checked);
    $display("and one long output stall filling the pipeline");
    if (errors == 0 && expected_hsl.size() == 0) begin
      $display("PASS rgb_to_hsl_converter");
    end else begin
      $display("FAIL rgb_to_hsl_converter");
    end
    $finish;
  end

endmodule

`default_nettype wire
